// File: sv/swtr_pkg.sv
// Shared types and constants for the sliding tile window reassignment block.
package swtr_pkg;

  localparam int COORD_W = 16;  // cell coordinate width, two's complement
  localparam int SLOT_W  = 6;   // slot index width on the result word

  typedef struct packed {
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
  } in_word_t;

  typedef struct packed {
    logic        [SLOT_W-1:0]  slot_index;
    logic signed [COORD_W-1:0] cell_x;
    logic signed [COORD_W-1:0] cell_y;
    logic                      last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;     // zero one occupancy entry (post-reset sweep)
    logic load_centre;  // latch new centre, zero freed/taken counts
    logic p1_read;      // read slot cell at scan address
    logic p1_map;       // window test, read occupancy at cell index
    logic p1_decide;    // mark cell covered or push slot on freed list
    logic p2_read;      // read occupancy at scan cell and next freed slot
    logic p2_decide;    // pair uncovered cell with freed slot, clear entry
    logic step;         // advance scan column/row
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic same_centre;  // input word equals stored centre
    logic scan_done;    // scan counters at final position
    logic uncovered;    // registered occupancy read is zero
    logic out_busy;     // output register full and not being taken
  } dp_stat_t;

endpackage

// File: sv/swtr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/swtr_ctrl.sv
// Controller state machine: reset sweep, slot sort pass, pairing pass.
module swtr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swtr_pkg::dp_stat_t   stat,
  output swtr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P1_READ,
    ST_P1_MAP,
    ST_P1_DECIDE,
    ST_P2_READ,
    ST_P2_DECIDE
  } state_t;

  state_t state;
  state_t state_next;
  logic   stall;

  assign in_ready = (state == ST_IDLE);
  assign stall    = stat.uncovered & stat.out_busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.step     = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && !stat.same_centre) begin
          cmd.load_centre = 1'b1;
          state_next      = ST_P1_READ;
        end
      end
      ST_P1_READ: begin
        cmd.p1_read = 1'b1;
        state_next  = ST_P1_MAP;
      end
      ST_P1_MAP: begin
        cmd.p1_map = 1'b1;
        state_next = ST_P1_DECIDE;
      end
      ST_P1_DECIDE: begin
        cmd.p1_decide = 1'b1;
        cmd.step      = 1'b1;
        state_next    = stat.scan_done ? ST_P2_READ : ST_P1_READ;
      end
      ST_P2_READ: begin
        cmd.p2_read = 1'b1;
        state_next  = ST_P2_DECIDE;
      end
      ST_P2_DECIDE: begin
        cmd.p2_decide = 1'b1;
        if (!stall) begin
          cmd.step   = 1'b1;
          state_next = stat.scan_done ? ST_IDLE : ST_P2_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/swtr_dp.sv
// Datapath: scan counters, slot/occupancy/freed-list memories, output register.
module swtr_dp #(
  parameter int GRID_SIDE = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swtr_pkg::in_word_t   in_data,
  input  swtr_pkg::ctrl_cmd_t  cmd,
  output swtr_pkg::dp_stat_t   stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output swtr_pkg::out_word_t  out_data
);

  localparam int SLOTS = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int HALF  = GRID_SIDE / 2;
  localparam int C_W   = swtr_pkg::COORD_W;

  localparam logic [CW-1:0]    LAST_POS = CW'(GRID_SIDE - 1);
  localparam logic [C_W-1:0]   HALF_C   = C_W'(HALF);
  localparam logic [C_W-1:0]   SIDE_C   = C_W'(GRID_SIDE);
  localparam logic [IDX_W-1:0] SIDE_I   = IDX_W'(GRID_SIDE);

  logic [CW-1:0]    col, row;
  logic [CNT_W-1:0] freed, taken;
  logic [C_W-1:0]   cx, cy;
  logic [SLOTS-1:0] slot_vld;
  logic             rd_vld;
  logic [IDX_W-1:0] slot_reg, m_reg;
  logic             in_win;

  logic [IDX_W-1:0] scan_addr;
  logic [2*C_W-1:0] slot_rd;
  logic [C_W-1:0]   sx, sy, dx, dy, nx, ny;
  logic             win_c;
  logic [IDX_W-1:0] m_c;
  logic             map_rd;
  logic [IDX_W-1:0] freed_rd;
  logic             kept, pair, out_busy, last_c;

  logic             map_we;
  logic [IDX_W-1:0] map_waddr, map_raddr;

  assign scan_addr = IDX_W'(col) + IDX_W'(row) * SIDE_I;

  // never-written slots read as their reset cell
  assign sx = rd_vld ? slot_rd[C_W-1:0]     : C_W'(col) - HALF_C;
  assign sy = rd_vld ? slot_rd[2*C_W-1:C_W] : C_W'(row) - HALF_C;

  assign dx    = sx - cx + HALF_C;
  assign dy    = sy - cy + HALF_C;
  assign win_c = (dx < SIDE_C) && (dy < SIDE_C);
  assign m_c   = IDX_W'(dx[CW-1:0]) + IDX_W'(dy[CW-1:0]) * SIDE_I;

  assign kept     = in_win & ~map_rd;
  assign out_busy = out_valid & ~out_ready;
  assign pair     = cmd.p2_decide & ~map_rd & ~out_busy;
  assign nx       = cx - HALF_C + C_W'(col);
  assign ny       = cy - HALF_C + C_W'(row);
  assign last_c   = ((taken + CNT_W'(1)) == freed);

  assign stat.same_centre = ($unsigned(in_data.centre_x) == cx) &&
                            ($unsigned(in_data.centre_y) == cy);
  assign stat.scan_done   = (col == LAST_POS) && (row == LAST_POS);
  assign stat.uncovered   = ~map_rd;
  assign stat.out_busy    = out_busy;

  // occupancy map port muxing
  assign map_we    = cmd.clear_wr | (cmd.p1_decide & kept) | cmd.p2_decide;
  assign map_waddr = cmd.p1_decide ? m_reg : scan_addr;
  assign map_raddr = cmd.p1_map ? m_c : scan_addr;

  swtr_ram #(.WIDTH(2 * C_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (pair),
    .waddr (freed_rd),
    .wdata ({ny, nx}),
    .re    (cmd.p1_read),
    .raddr (scan_addr),
    .rdata (slot_rd)
  );

  swtr_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (cmd.p1_decide),
    .re    (cmd.p1_map | cmd.p2_read),
    .raddr (map_raddr),
    .rdata (map_rd)
  );

  swtr_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_freed_ram (
    .clk   (clk),
    .we    (cmd.p1_decide & ~kept),
    .waddr (freed[IDX_W-1:0]),
    .wdata (slot_reg),
    .re    (cmd.p2_read),
    .raddr (taken[IDX_W-1:0]),
    .rdata (freed_rd)
  );

  // scan counters: column outer, row inner, wrap to origin
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.step) begin
      if (row == LAST_POS) begin
        row <= '0;
        col <= (col == LAST_POS) ? '0 : col + CW'(1);
      end else begin
        row <= row + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freed    <= '0;
      taken    <= '0;
      cx       <= '0;
      cy       <= '0;
      slot_vld <= '0;
    end else begin
      if (cmd.load_centre) begin
        freed <= '0;
        taken <= '0;
        cx    <= in_data.centre_x;
        cy    <= in_data.centre_y;
      end
      if (cmd.p1_decide && !kept) begin
        freed <= freed + CNT_W'(1);
      end
      if (pair) begin
        taken              <= taken + CNT_W'(1);
        slot_vld[freed_rd] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p1_read) begin
      rd_vld   <= slot_vld[scan_addr];
      slot_reg <= scan_addr;
    end
    if (cmd.p1_map) begin
      in_win <= win_c;
      m_reg  <= m_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pair) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pair) begin
      out_data.slot_index <= swtr_pkg::SLOT_W'(freed_rd);
      out_data.cell_x     <= nx;
      out_data.cell_y     <= ny;
      out_data.last       <= last_c;
    end
  end

endmodule

// File: sv/sliding_window_tile_reassign.sv
// Sliding tile window reassignment: top level with controller and datapath.
//
// Keeps a GRID_SIDE x GRID_SIDE table of tile slots and the window centre.
// Each input word names a new centre cell. A word equal to the stored centre
// is taken and gives nothing. Otherwise the block runs two scans: a sort pass
// over all GRID_SIDE^2 slots (slot memory read, window test plus occupancy
// read, occupancy or freed-list write), then a pairing pass over all window
// cells (occupancy and freed-list read, then pairing). Every freed slot is
// paired with an uncovered window cell in column-major order and produces one
// result word; the final one carries last. A pairing waits while the output
// register is full. The input side is ready only between updates. After reset
// the occupancy memory is swept clear before the first word is taken. Cell
// arithmetic wraps modulo 2^16, so the window is toroidal at the edge of the
// coordinate range. GRID_SIDE ranges from 2 to 8.
module sliding_window_tile_reassign #(
  parameter int GRID_SIDE = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  swtr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output swtr_pkg::out_word_t out_data
);

  swtr_pkg::ctrl_cmd_t cmd;
  swtr_pkg::dp_stat_t  stat;

  swtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swtr_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // no word is taken right after reset: the clearing sweep runs first
  a_sweep_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("input taken during post-reset sweep");

  // a new centre is only latched from an accepted word
  a_centre_from_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load_centre |-> (in_valid && in_ready))
    else $error("centre loaded without an accepted word");

  // a pairing blocked by a full output register stays pending
  a_pair_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.p2_decide && stat.uncovered && stat.out_busy) |=> cmd.p2_decide)
    else $error("stalled pairing dropped");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the sliding tile window reassignment block.
`timescale 1ns / 1ps

module tb_top;

  localparam int SIDE        = 8;
  localparam int HALF        = SIDE / 2;
  localparam int SLOTS       = SIDE * SIDE;
  localparam int MOVE_ITEMS  = 160;            // centre moves in the random part
  localparam int UPDATE_CYC  = 5 * SLOTS + 1;  // one full update, no output stall
  localparam int HOLD_AT     = 300;            // result count that starts the long hold-off
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYC   = UPDATE_CYC + 80;
  localparam int IDLE_LIMIT  = 4 * (HOLD_CYCLES + UPDATE_CYC + SLOTS);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  swtr_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  swtr_pkg::out_word_t out_data;

  sliding_window_tile_reassign #(
    .GRID_SIDE(SIDE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;

  // Handshakes seen at the last rising edge, used by the falling-edge drivers.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  always @(posedge clk) begin
    in_taken  <= in_fire;
    out_taken <= out_fire;
  end

  // ---------------------------------------------------------------------------
  // Tile table mirror: cell held by each slot plus the current window centre.
  // Starts from the reset layout, slot (col,row) at cell (col-HALF, row-HALF).
  // ---------------------------------------------------------------------------
  logic [15:0] tile_cell_x [SLOTS];
  logic [15:0] tile_cell_y [SLOTS];
  logic [15:0] view_x = '0;
  logic [15:0] view_y = '0;

  swtr_pkg::out_word_t reassign_q [$];     // reassignments still owed by the block
  swtr_pkg::in_word_t  pending_centres [$];

  // Sort every slot into kept or freed against the new window, then hand the
  // freed slots, in freeing order, to the uncovered window cells in
  // column-major order. Each hand-off is one result word.
  task automatic predict_reassignments(input swtr_pkg::in_word_t w);
    logic [15:0]         cx, cy, dx, dy, nx, ny;
    bit                  covered [SLOTS];
    int                  freed [$];
    int                  s, m, n, made;
    swtr_pkg::out_word_t r;
    cx   = w.centre_x;
    cy   = w.centre_y;
    n    = 0;
    made = 0;
    if (cx == view_x && cy == view_y) return;  // same centre: nothing to do
    for (int col = 0; col < SIDE; col++) begin
      for (int row = 0; row < SIDE; row++) begin
        s  = col + row * SIDE;
        // Offsets wrap mod 2^16, which makes the window toroidal.
        dx = 16'(tile_cell_x[s] - cx + HALF);
        dy = 16'(tile_cell_y[s] - cy + HALF);
        if (dx < SIDE && dy < SIDE) begin
          m = int'(dx) + int'(dy) * SIDE;
          if (covered[m]) freed.push_back(s);   // duplicate of a kept cell
          else covered[m] = 1'b1;
        end else begin
          freed.push_back(s);
        end
      end
    end
    for (int col = 0; col < SIDE && n < freed.size(); col++) begin
      for (int row = 0; row < SIDE && n < freed.size(); row++) begin
        m = col + row * SIDE;
        if (!covered[m]) begin
          s  = freed[n];
          n++;
          nx = 16'(cx - HALF + col);
          ny = 16'(cy - HALF + row);
          tile_cell_x[s] = nx;
          tile_cell_y[s] = ny;
          r.slot_index = s[swtr_pkg::SLOT_W-1:0];
          r.cell_x     = nx;
          r.cell_y     = ny;
          r.last       = 1'b0;
          reassign_q.push_back(r);
          made++;
        end
      end
    end
    if (made > 0) reassign_q[reassign_q.size() - 1].last = 1'b1;
    view_x = cx;
    view_y = cy;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int col = 0; col < SIDE; col++) begin
        for (int row = 0; row < SIDE; row++) begin
          tile_cell_x[col + row * SIDE] = 16'(col - HALF);
          tile_cell_y[col + row * SIDE] = 16'(row - HALF);
        end
      end
    end else if (in_fire) begin
      predict_reassignments(in_data);
    end
  end

  // Gap drawn per word; every third block of 40 words runs back to back.
  function automatic int pick_gap(input int idx);
    if ((idx / 40) % 3 == 2) return 0;
    return $urandom_range(19, 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued centre words at the falling edge, holds each one
  // until taken, then waits its drawn gap.
  // ---------------------------------------------------------------------------
  int tx_wait  = 0;
  int tx_count = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_centres.size() > 0) begin
        in_data  <= pending_centres.pop_front();
        in_valid <= 1'b1;
        tx_wait  = pick_gap(tx_count);
        tx_count++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall after each taken word, and one long hold-off so the
  // output register backs up and the input side stalls while words keep coming.
  // ---------------------------------------------------------------------------
  int rx_wait  = 0;
  int rx_count = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_taken) begin
      rx_wait = (rx_count == HOLD_AT) ? HOLD_CYCLES : pick_gap(rx_count);
      out_ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= (rx_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: each taken result word against the oldest owed reassignment.
  int                  mismatches = 0;
  swtr_pkg::out_word_t owed;

  always @(posedge clk) begin
    if (out_fire) begin
      rx_count++;
      if (reassign_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d unexpected: slot %0d cell (%0d,%0d) last %0b", rx_count,
                   out_data.slot_index, out_data.cell_x, out_data.cell_y, out_data.last);
      end else begin
        owed = reassign_q.pop_front();
        if (out_data.slot_index !== owed.slot_index || out_data.cell_x !== owed.cell_x ||
            out_data.cell_y !== owed.cell_y || out_data.last !== owed.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: exp slot %0d cell (%0d,%0d) last %0b, ",
                     rx_count, owed.slot_index, owed.cell_x, owed.cell_y, owed.last,
                     "got slot %0d cell (%0d,%0d) last %0b",
                     out_data.slot_index, out_data.cell_x, out_data.cell_y, out_data.last);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. last_x/last_y track the centre the block will hold after every
  // queued word, so moves and repeats of the same centre can be told apart.
  // ---------------------------------------------------------------------------
  logic [15:0] last_x = '0;
  logic [15:0] last_y = '0;

  function automatic bit queue_centre(input int x, input int y);
    swtr_pkg::in_word_t w;
    bit                 moved;
    w.centre_x = 16'(x);
    w.centre_y = 16'(y);
    moved = (w.centre_x != last_x) || (w.centre_y != last_y);
    last_x = w.centre_x;
    last_y = w.centre_y;
    pending_centres.push_back(w);
    return moved;
  endfunction

  initial begin
    int moves, kind, dx, dy;
    moves = 0;

    // Directed: repeat of the reset centre, one-cell steps, half and full side
    // shifts, a far jump freeing every slot, the signed wrap at both extremes,
    // and alternating bit patterns.
    void'(queue_centre(0, 0));
    void'(queue_centre(1, 0));
    void'(queue_centre(1, 1));
    void'(queue_centre(0, 0));
    void'(queue_centre(-1, -1));
    void'(queue_centre(3, -2));
    void'(queue_centre(3 + HALF, -2 + HALF));
    void'(queue_centre(3 + SIDE - 1, -2));
    void'(queue_centre(3 + SIDE, -2 + SIDE));
    void'(queue_centre(100, -100));
    void'(queue_centre(100, -100));
    void'(queue_centre(32767, 32767));
    void'(queue_centre(-32768, -32768));
    void'(queue_centre(-32767, 32767));
    void'(queue_centre(32764, -32765));
    void'(queue_centre(32766, -32768));
    void'(queue_centre(-1, 0));
    void'(queue_centre(0, -32768));
    void'(queue_centre(-32768, 0));
    void'(queue_centre(16'h5555, 16'hAAAA));
    void'(queue_centre(16'hAAAA, 16'h5555));
    void'(queue_centre(16'hFFFF, 16'hFFFF));
    void'(queue_centre(0, 0));

    // Random: mostly short walks that keep part of the window, plus repeats,
    // medium steps, far jumps and jumps onto the wrap edge.
    while (moves < MOVE_ITEMS) begin
      kind = $urandom_range(99, 0);
      if (kind < 65) begin
        dx = int'($urandom_range(6, 0)) - 3;
        dy = int'($urandom_range(6, 0)) - 3;
      end else if (kind < 75) begin
        dx = 0;
        dy = 0;
      end else if (kind < 88) begin
        dx = int'($urandom_range(2 * SIDE + 4, 0)) - SIDE - 2;
        dy = int'($urandom_range(2 * SIDE + 4, 0)) - SIDE - 2;
      end else if (kind < 94) begin
        dx = int'($urandom_range(16'hFFFF, 0)) - int'(last_x);
        dy = int'($urandom_range(16'hFFFF, 0)) - int'(last_y);
      end else begin
        dx = int'($urandom_range(16'h8003, 16'h7FFC)) - int'(last_x);
        dy = int'($urandom_range(16'h8003, 16'h7FFC)) - int'(last_y);
      end
      if (queue_centre(int'(last_x) + dx, int'(last_y) + dy)) moves++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_centres.size() > 0 || in_valid) @(posedge clk);
    while (reassign_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/swtr_pkg.sv
sv/swtr_ram.sv
sv/swtr_ctrl.sv
sv/swtr_dp.sv
sv/sliding_window_tile_reassign.sv
test/tb_top.sv
